// ===== rtl/cpr_pkg.sv =====
// Shared types and constants for the clock page replacement block.
// Used by every module under rtl and by the port checker; no dependencies.
package cpr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int CFG_W     = 4;
    localparam int OUTC_W    = 2;
    localparam int RES_W     = OUTC_W + FRAME_W + PAGE_BITS;
    localparam int M_DATA_W  = ((RES_W + 7) / 8) * 8;
    localparam int S_DATA_W  = ((PAGE_BITS + 7) / 8) * 8;

    localparam logic [OUTC_W-1:0] OUTC_HIT     = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_FILL    = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_REPLACE = 2'd2;

    localparam logic [CFG_W-1:0] CFG_LIMIT_RST = CFG_W'(FRAMES);

    // Frame store access: one read index, one write index per cycle.
    typedef struct packed {
        logic [FRAME_W-1:0]   rd_idx;
        logic [FRAME_W-1:0]   wr_idx;
        logic                 wr_page;
        logic                 set_ref;
        logic                 clr_ref;
        logic [PAGE_BITS-1:0] page;
    } t_store_cmd;

    typedef struct packed {
        logic [PAGE_BITS-1:0] rd_page;
        logic                 rd_ref;
        logic                 match;
    } t_store_sts;

    typedef struct packed {
        logic [PAGE_BITS-1:0] evicted;
        logic [FRAME_W-1:0]   frame;
        logic [OUTC_W-1:0]    outcome;
    } t_result;

endpackage

// ===== rtl/clock_page_replacement_top.sv =====
// Top level of the second-chance clock page replacement block.
// Instantiates cpr_seq and cpr_store; uses cpr_pkg.
//
//  channel   direction  beat contents (low bit first)
//  s_*       in         tdata: page[15:0]
//  m_*       out        tdata: outcome[1:0], frame[4:2], evicted_page[20:5]
//  apb       in/out     reg 0 at byte 0: frames_in_use[3:0]
//
// An access searches the filled frames for a hit and, on a miss with the ring
// full, sweeps the clock from the hand to find a frame to replace:
// the single page comparator and reference-bit port step one frame a cycle.
// s_tready drops from the accepted beat until the result is handed to the
// output register; that register frees the core while m_tready is low.
// Reset is synchronous, active low; reference bits, fill count, hand and
// frames_in_use (back to 8) reset at once, frame pages need no clearing.
module clock_page_replacement_top import cpr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] page
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [1:0] outcome, [4:2] frame, [20:5] evicted_page
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [CFG_W-1:0]    r_cfg_lim;
    logic [CNT_W-1:0]    w_lim;
    logic                r_m_vld;
    logic [M_DATA_W-1:0] r_m_data;
    logic                w_start;
    logic                w_take;
    logic                w_res_vld;
    logic                w_ready;
    t_result             w_res;
    t_store_cmd          w_cmd;
    t_store_sts          w_sts;

    // Register map: only index 0 is backed, paddr[2] selects beyond it.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - CFG_W){1'b0}}, r_cfg_lim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lim <= CFG_LIMIT_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_cfg_lim <= pwdata[CFG_W-1:0];
        end
    end

    // Clamp the limit into 1..FRAMES.
    always_comb begin
        priority if (r_cfg_lim == '0) begin
            w_lim = CNT_W'(1);
        end else if (CNT_W'(r_cfg_lim) > CNT_W'(FRAMES)) begin
            w_lim = CNT_W'(FRAMES);
        end else begin
            w_lim = CNT_W'(r_cfg_lim);
        end
    end

    assign s_tready = w_ready;
    assign w_start  = s_tvalid && w_ready;
    // Advance the result into the output register once it is free.
    assign w_take   = w_res_vld && (!r_m_vld || m_tready);

    cpr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_page     (s_tdata[PAGE_BITS-1:0]),
        .i_lim      (w_lim),
        .i_sts      (w_sts),
        .i_res_take (w_take),
        .o_cmd      (w_cmd),
        .o_ready    (w_ready),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res)
    );

    cpr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_take) begin
            r_m_vld <= 1'b1;
        end else if (m_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_m_data <= M_DATA_W'(w_res);
        end
    end

    assign m_tvalid = r_m_vld;
    assign m_tdata  = r_m_data;

endmodule

// ===== rtl/cpr_store.sv =====
// Frame store: page number and reference bit of each frame, plus the one
// page comparator shared by the hit search. Depends on cpr_pkg.
module cpr_store import cpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_cmd i_cmd,
    output t_store_sts o_sts
);

    logic [PAGE_BITS-1:0] r_page [FRAMES];
    logic [FRAMES-1:0]    r_ref;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_page) begin
            r_page[i_cmd.wr_idx] <= i_cmd.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= '0;
        end else if (i_cmd.set_ref) begin
            r_ref[i_cmd.wr_idx] <= 1'b1;
        end else if (i_cmd.clr_ref) begin
            r_ref[i_cmd.wr_idx] <= 1'b0;
        end
    end

    assign o_sts.rd_page = r_page[i_cmd.rd_idx];
    assign o_sts.rd_ref  = r_ref[i_cmd.rd_idx];
    assign o_sts.match   = (r_page[i_cmd.rd_idx] == i_cmd.page);

endmodule

// ===== rtl/cpr_seq.sv =====
// Sequencer: walks the frame index for the hit search and the clock sweep,
// decides hit, fill or replace, and holds the result. Depends on cpr_pkg.
module cpr_seq import cpr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [CNT_W-1:0]     i_lim,
    input  t_store_sts           i_sts,
    input  logic                 i_res_take,
    output t_store_cmd           o_cmd,
    output logic                 o_ready,
    output logic                 o_res_vld,
    output t_result              o_res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SRCH  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [FRAME_W-1:0]   r_idx, n_idx;
    logic [FRAME_W-1:0]   r_hand, n_hand;
    logic [CNT_W-1:0]     r_filled, n_filled;
    logic [PAGE_BITS-1:0] r_page, n_page;
    t_result              r_res, n_res;

    logic [CNT_W-1:0]   w_idx_inc;
    logic [FRAME_W-1:0] w_idx_next;
    logic               w_hit;
    logic               w_last;

    assign w_idx_inc  = CNT_W'(r_idx) + CNT_W'(1);
    assign w_idx_next = (w_idx_inc < i_lim) ? w_idx_inc[FRAME_W-1:0] : '0;
    assign w_hit      = (CNT_W'(r_idx) < r_filled) && i_sts.match;
    assign w_last     = !(w_idx_inc < r_filled);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_hand   = r_hand;
        n_filled = r_filled;
        n_page   = r_page;
        n_res    = r_res;
        o_cmd         = '0;
        o_cmd.rd_idx  = r_idx;
        o_cmd.wr_idx  = r_idx;
        o_cmd.page    = r_page;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_page  = i_page;
                    n_idx   = '0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                priority if (w_hit) begin
                    o_cmd.set_ref = 1'b1;
                    n_res   = '{evicted: '0, frame: r_idx, outcome: OUTC_HIT};
                    n_state = S_DONE;
                end else if (!w_last) begin
                    n_idx = r_idx + FRAME_W'(1);
                end else if (r_filled < i_lim) begin
                    // Free frame left: fill it, the hand stays put.
                    o_cmd.wr_idx  = r_filled[FRAME_W-1:0];
                    o_cmd.wr_page = 1'b1;
                    o_cmd.set_ref = 1'b1;
                    n_filled = r_filled + CNT_W'(1);
                    n_res    = '{evicted: '0, frame: r_filled[FRAME_W-1:0],
                                 outcome: OUTC_FILL};
                    n_state  = S_DONE;
                end else begin
                    // Ring full: start the sweep at the hand, wrapped to the limit.
                    n_idx   = (CNT_W'(r_hand) >= i_lim) ? '0 : r_hand;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (i_sts.rd_ref) begin
                    o_cmd.clr_ref = 1'b1;
                    n_idx = w_idx_next;
                end else begin
                    o_cmd.wr_page = 1'b1;
                    o_cmd.set_ref = 1'b1;
                    n_hand  = w_idx_next;
                    n_res   = '{evicted: i_sts.rd_page, frame: r_idx,
                                outcome: OUTC_REPLACE};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hand   <= '0;
            r_filled <= '0;
        end else begin
            r_state  <= n_state;
            r_hand   <= n_hand;
            r_filled <= n_filled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_page <= n_page;
        r_res  <= n_res;
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_DONE);
    assign o_res     = r_res;

endmodule

// ===== rtl/cpr_check.sv =====
// Port-level checker for clock_page_replacement_top, bound to the top level.
// Uses cpr_pkg for field widths and outcome codes.
module cpr_check import cpr_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [OUTC_W-1:0]    w_outc;
    logic [PAGE_BITS-1:0] w_evict;

    assign w_outc  = m_tdata[OUTC_W-1:0];
    assign w_evict = m_tdata[OUTC_W+FRAME_W +: PAGE_BITS];

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The core is busy in the cycle after taking a beat.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    a_outc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (w_outc == OUTC_HIT || w_outc == OUTC_FILL ||
                      w_outc == OUTC_REPLACE))
        else $error("unknown outcome code");

    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && w_outc != OUTC_REPLACE |-> w_evict == '0)
        else $error("evicted page nonzero without replacement");

endmodule

bind clock_page_replacement_top cpr_check u_cpr_check (.*);

// ===== bench/tb.sv =====
// Self-checking bench for clock_page_replacement_top: stream driver, result monitor,
// APB register writes and a clock-replacement predictor in one module.
// Depends on cpr_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
    import cpr_pkg::*;

    localparam int          RAND_ITEMS   = 118;     // per random phase, eight phases
    localparam int          DRAIN_CYCLES = 40;      // settling time after each drain, in cycles
    localparam int          LONG_HOLD    = 300;     // receiver hold-off, in cycles
    localparam int          IDLE_PCT     = 9;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam logic [2:0]  LIMIT_ADDR   = 3'd0;    // frames_in_use

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;              // [15:0] page
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;                   // [1:0] outcome, [4:2] frame, [20:5] evicted_page
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    clock_page_replacement_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stimulus and scoreboard storage.
    logic [PAGE_BITS-1:0] page_beats_q[$];          // pages waiting for the driver
    t_result              access_results_due[$];    // predicted results, oldest first
    logic                 s_took   = 1'b0;          // input beat accepted at the last edge
    logic                 no_idle  = 1'b0;          // suppress random idling on both sides
    logic                 hold_req = 1'b0;          // ask the receiver for one long hold-off
    logic                 hold_done = 1'b0;
    int                   stall_left = 0;
    int                   fail_count = 0;
    int unsigned          cyc = 0;
    logic [3:0]           rand_limits[8] = '{4'd8, 4'd5, 4'd1, 4'd15, 4'd3, 4'd0, 4'd6, 4'd2};

    // Predictor state: a private copy of the frame ring and the register.
    logic [PAGE_BITS-1:0] held_page[FRAMES];
    bit                   ref_bits[FRAMES];
    int unsigned          n_filled = 0;
    int unsigned          hand     = 0;
    logic [3:0]           limit_cfg = CFG_LIMIT_RST;

    function automatic int unsigned eff_limit(input logic [3:0] cfg);
        if (cfg == 4'd0)
            return 1;
        if (cfg > FRAMES)
            return FRAMES;
        return cfg;
    endfunction

    // One page access through the second-chance ring; updates the private state.
    function automatic t_result clock_replace_access(input logic [PAGE_BITS-1:0] pg);
        t_result     r;
        int unsigned lim;
        int unsigned h;
        bit          found;
        r     = '0;
        found = 1'b0;
        lim   = eff_limit(limit_cfg);
        // Hit search covers every filled frame, even ones above a lowered limit.
        for (int k = 0; k < n_filled; k++) begin
            if (!found && held_page[k] == pg) begin
                ref_bits[k] = 1'b1;
                r.frame     = FRAME_W'(k);
                r.outcome   = OUTC_HIT;
                found       = 1'b1;
            end
        end
        if (!found) begin
            if (n_filled < lim) begin
                r.frame             = FRAME_W'(n_filled);
                r.outcome           = OUTC_FILL;
                held_page[n_filled] = pg;
                ref_bits[n_filled]  = 1'b1;
                n_filled++;
            end else begin
                // Hand beyond a lowered limit restarts at frame 0.
                h = (hand >= lim) ? 0 : hand;
                while (ref_bits[h]) begin
                    ref_bits[h] = 1'b0;
                    h = (h + 1 < lim) ? h + 1 : 0;
                end
                r.frame      = FRAME_W'(h);
                r.evicted    = held_page[h];
                r.outcome    = OUTC_REPLACE;
                held_page[h] = pg;
                ref_bits[h]  = 1'b1;
                hand         = (h + 1 < lim) ? h + 1 : 0;
            end
        end
        return r;
    endfunction

    // Driver: present the next page on the falling edge once the previous beat is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_took) begin
            if (page_beats_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= page_beats_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that lets the block back up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready   <= 1'b0;
            stall_left <= LONG_HOLD;
            hold_done  <= 1'b1;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on each accepted page beat, check each accepted result beat.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        got = t_result'(m_tdata[RES_W-1:0]);
        if (!i_rst_n) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                access_results_due.push_back(clock_replace_access(s_tdata[PAGE_BITS-1:0]));
            if (m_tvalid && m_tready) begin
                if (access_results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing predicted: outcome %0d frame %0d evicted %h",
                             $time, got.outcome, got.frame, got.evicted);
                end else begin
                    want = access_results_due.pop_front();
                    if (got.outcome !== want.outcome) begin
                        fail_count++;
                        $display("%0t: outcome expected %0d actual %0d",
                                 $time, want.outcome, got.outcome);
                    end
                    if (got.frame !== want.frame) begin
                        fail_count++;
                        $display("%0t: frame expected %0d actual %0d",
                                 $time, want.frame, got.frame);
                    end
                    if (got.evicted !== want.evicted) begin
                        fail_count++;
                        $display("%0t: evicted_page expected %h actual %h",
                                 $time, want.evicted, got.evicted);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("clock_page_replacement_top verification failed");
            $finish;
        end
    end

    // Write frames_in_use over APB, read it back, and mirror it in the predictor.
    task automatic set_limit(input logic [3:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {28'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        limit_cfg = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[3:0] !== val) begin
            fail_count++;
            $display("%0t: frames_in_use readback expected %0d actual %0d",
                     $time, val, prdata[3:0]);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold the sender until every predicted result has come back, then let the block settle.
    // Check a little after the falling edge so the driver's updates have landed.
    task automatic drain();
        @(negedge i_clk);
        #1;
        while (page_beats_q.size() != 0 || s_tvalid || access_results_due.size() != 0) begin
            @(negedge i_clk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [PAGE_BITS-1:0] pool[$];
        int unsigned          n_pages;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Limit 3: fill, hit, then a full sweep that clears every bit and wraps; the next
        // miss clears the bit of the recently hit frame at the hand and evicts the frame after it.
        set_limit(4'd3);
        @(posedge i_clk);
        page_beats_q = '{16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF,
                         16'h1234};
        drain();

        // Raise to 8: filling resumes at the next free frame, then one replacement.
        set_limit(4'd8);
        @(posedge i_clk);
        page_beats_q = '{16'h0001, 16'h0002, 16'h0004, 16'h8000, 16'h7FFF, 16'h4000};
        drain();

        // Lower to 2: a page above the limit still hits; the hand wraps inside the limit.
        set_limit(4'd2);
        @(posedge i_clk);
        page_beats_q = '{16'h8000, 16'h0F0F, 16'hF0F0};
        drain();

        // Zero acts as one frame, fifteen as all eight.
        set_limit(4'd0);
        @(posedge i_clk);
        page_beats_q = '{16'h0100, 16'h0200};
        drain();
        set_limit(4'd15);
        @(posedge i_clk);
        page_beats_q = '{16'h7FFF, 16'h3C3C};
        drain();

        // Random phases: mostly a small working set a little larger than the ring,
        // so hits, sweeps and evictions all recur; the rest are fresh pages.
        for (int p = 0; p < 8; p++) begin
            set_limit(rand_limits[p]);
            pool.delete();
            n_pages = eff_limit(rand_limits[p]) + $urandom_range(1, 4);
            repeat (n_pages) pool.push_back(PAGE_BITS'($urandom));
            @(posedge i_clk);
            no_idle = (p == 2);
            repeat (RAND_ITEMS) begin
                if ($urandom_range(99) < 75)
                    page_beats_q.push_back(pool[$urandom_range(pool.size() - 1)]);
                else
                    page_beats_q.push_back(PAGE_BITS'($urandom));
            end
            // Stall the result side while the sender keeps offering beats.
            if (p == 1)
                hold_req = 1'b1;
            drain();
        end

        if (fail_count == 0 && access_results_due.size() == 0)
            $display("clock_page_replacement_top verification clean");
        else
            $display("clock_page_replacement_top verification failed");
        $finish;
    end

endmodule
